### design/ktsa_pkg.sv
// Package for the keyed time-strip accumulator.
// Shared types, field widths and status codes; no dependencies.
`default_nettype none
package ktsa_pkg;

    localparam int VERTICES_DEF = 1024;
    localparam int SLOTS_DEF    = 8;
    localparam int FUNCS_DEF    = 5;

    localparam int KEY_W = 25;
    localparam int SUM_W = 48;
    localparam int VAL_W = 32;
    localparam int TIME_W = 24;
    localparam int LEN_W = 16;
    localparam int VIN_W = 10;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    // item handed from front to back; vertex already reduced modulo VERTICES
    typedef struct packed {
        logic [15:0]              vtx;
        logic [2:0]               fn;
        logic signed [VAL_W-1:0]  val;
        logic signed [KEY_W-1:0]  key;
    } t_item;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_RD,
        B_CHK,
        B_SUM,
        B_EMIT
    } t_back_state;

endpackage
`default_nettype wire

### design/ktsa_fifo.sv
// Two-entry queue between front and back.
// Depends on nothing but its width parameter.
`default_nettype none
module ktsa_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

### design/ktsa_front.sv
// Front end: accepts items, divides time by strip length (one bit a cycle)
// and reduces the vertex modulo VERTICES. Uses ktsa_pkg.
`default_nettype none
module ktsa_front
    import ktsa_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_enable,
    input  wire logic [LEN_W-1:0]  i_strip_len,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [VIN_W-1:0]  i_vertex,
    input  wire logic [2:0]        i_func,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic [TIME_W-1:0] i_time,
    output logic                   o_push,
    output t_item                  o_item,
    input  wire logic              i_full
);
    localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int VSH = 20;
    localparam int PW  = VIN_W + VSH + 1;
    localparam int MW  = VIN_W + 17;
    // floor(2^VSH / VERTICES): quotient estimate is exact or one low
    localparam logic [PW-1:0] RECIP = PW'((2**VSH) / VERTICES);
    localparam logic [MW-1:0] VMOD  = MW'(VERTICES);

    t_front_state r_state, n_state;
    logic [4:0]        r_step;
    logic [TIME_W-1:0] r_quo;
    logic [LEN_W-1:0]  r_rem, r_len;
    logic [VIN_W-1:0]  r_vsh;
    logic [VIN_W-1:0]  r_vq;
    logic [VW-1:0]     r_vrem;
    logic [2:0]        r_fn;
    logic [VAL_W-1:0]  r_val;

    logic [LEN_W:0] trial;
    logic           take;
    logic [PW-1:0]  vprod;
    logic [MW-1:0]  vback;
    logic [MW-1:0]  vrem0;
    logic           vtake;

    assign trial  = {r_rem, r_quo[TIME_W-1]};
    assign take   = (trial >= {1'b0, r_len});
    assign vprod  = PW'(r_vsh) * RECIP;
    assign vback  = MW'(r_vq) * VMOD;
    assign vrem0  = MW'(r_vsh) - vback;
    assign vtake  = (vrem0 >= VMOD);

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = i_enable;
                if (i_enable && i_valid) n_state = F_DIV;
            end
            F_DIV: begin
                if (r_step == 5'(TIME_W - 1)) n_state = F_PUSH;
            end
            F_PUSH: begin
                o_push = !i_full;
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_item     = '0;
        o_item.vtx = 16'(r_vrem);
        o_item.fn  = r_fn;
        o_item.val = r_val;
        o_item.key = $signed({1'b0, r_quo}) - 25'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == F_IDLE) begin
            r_step <= '0;
            r_quo  <= i_time;
            r_rem  <= '0;
            r_len  <= (i_strip_len == '0) ? LEN_W'(1) : i_strip_len;
            r_vsh  <= i_vertex;
            r_vrem <= '0;
            r_fn   <= i_func;
            r_val  <= i_value;
        end else if (r_state == F_DIV) begin
            r_step <= r_step + 5'd1;
            r_quo  <= {r_quo[TIME_W-2:0], take};
            r_rem  <= take ? LEN_W'(trial - {1'b0, r_len}) : trial[LEN_W-1:0];
            // vertex modulo: quotient estimate, then one compare and subtract
            if (r_step == 5'd0) begin
                r_vq <= VIN_W'(vprod >> VSH);
            end
            if (r_step == 5'd1) begin
                r_vrem <= VW'(vtake ? vrem0 - VMOD : vrem0);
            end
        end
    end
endmodule
`default_nettype wire

### design/ktsa_back.sv
// Back end: slot search, slot table and accumulator memories, strip
// tracking and the output register. Uses ktsa_pkg.
`default_nettype none
module ktsa_back
    import ktsa_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF,
    parameter int SLOTS    = SLOTS_DEF,
    parameter int FUNCS    = FUNCS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    output logic            o_clr_done,
    input  wire logic       i_empty,
    input  wire t_item      i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [135:0]    o_data
);
    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = VW + SW;
    localparam int EW = 1 + KEY_W + FUNCS;
    localparam logic signed [SUM_W:0] SMAX = (SUM_W+1)'(64'sd140737488355327);
    localparam logic signed [SUM_W:0] SMIN = (SUM_W+1)'(-64'sd140737488355328);

    // slot entry: {valid, strip, accumulators written}
    logic [EW-1:0]    r_slot_mem [2**AW];
    logic [SUM_W-1:0] r_sum_mem  [2**(AW+3)];
    logic [EW-1:0]    r_ent;
    logic [SUM_W-1:0] r_sum_rd;

    t_back_state r_state, n_state;
    logic [AW-1:0]  r_clr;
    t_item          r_item;
    logic [SW-1:0]  r_slot;
    logic [FUNCS-1:0] r_mask;
    logic           r_err, r_seen;
    logic signed [KEY_W-1:0] r_lo, r_hi;
    logic [SW-1:0]  r_deep;

    // pending result
    logic [1:0]              r_st;
    logic [2:0]              r_oslot;
    logic signed [KEY_W-1:0] r_okey;
    logic signed [SUM_W-1:0] r_osum;
    logic                    r_ovalid;
    logic [135:0]            r_odata;

    logic [VW-1:0]  vtx;
    logic           ent_v;
    logic [KEY_W-1:0] ent_k;
    logic [FUNCS-1:0] ent_m;
    logic           fn_ok;
    logic [FUNCS-1:0] fn_bit;
    logic           hit;
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W:0]   wide;
    logic signed [SUM_W-1:0] sat;
    logic                    emit_go;

    assign vtx    = r_item.vtx[VW-1:0];
    assign ent_v  = r_ent[EW-1];
    assign ent_k  = r_ent[EW-2 -: KEY_W];
    assign ent_m  = r_ent[FUNCS-1:0];
    assign fn_ok  = (r_item.fn < 3'(FUNCS));
    assign fn_bit = fn_ok ? (FUNCS'(1) << r_item.fn) : '0;
    assign hit    = !ent_v || ($signed(ent_k) == r_item.key);
    assign old_sum = (r_mask & fn_bit) != '0 ? $signed(r_sum_rd) : '0;
    assign wide    = $signed({old_sum[SUM_W-1], old_sum})
                   + $signed({{(SUM_W+1-VAL_W){r_item.val[VAL_W-1]}}, r_item.val});
    assign sat     = (wide > SMAX) ? SMAX[SUM_W-1:0]
                   : (wide < SMIN) ? SMIN[SUM_W-1:0] : wide[SUM_W-1:0];
    assign emit_go = !r_ovalid || i_ready;

    assign o_clr_done = (r_state != B_CLR);
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            B_CLR:  if (r_clr == '1) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = r_err ? B_EMIT : B_RD;
                end
            end
            B_RD:   n_state = B_CHK;
            B_CHK: begin
                if (hit) n_state = fn_ok ? B_SUM : B_EMIT;
                else if (r_slot == SW'(SLOTS - 1)) n_state = B_EMIT;
                else n_state = B_RD;
            end
            B_SUM:  n_state = B_EMIT;
            B_EMIT: if (emit_go) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == B_CLR) begin
            r_slot_mem[r_clr] <= '0;
        end else if (r_state == B_CHK && hit) begin
            r_slot_mem[{vtx, r_slot}] <= {1'b1, r_item.key, ent_m | fn_bit};
        end
        if (r_state == B_RD) begin
            r_ent <= r_slot_mem[{vtx, r_slot}];
        end
        if (r_state == B_CHK) begin
            r_sum_rd <= r_sum_mem[{vtx, r_slot, r_item.fn}];
        end
        if (r_state == B_SUM) begin
            r_sum_mem[{vtx, r_slot, r_item.fn}] <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLR;
            r_clr    <= '0;
            r_err    <= 1'b0;
            r_seen   <= 1'b0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_deep   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) r_clr <= r_clr + AW'(1);
            // a new result may replace one leaving in the same cycle
            if (r_state == B_EMIT && emit_go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty && !r_err) begin
                        r_seen <= 1'b1;
                        if (!r_seen || i_item.key < r_lo) r_lo <= i_item.key;
                        if (!r_seen || i_item.key > r_hi) r_hi <= i_item.key;
                    end
                end
                B_CHK: begin
                    if (hit) begin
                        if (r_slot > r_deep) r_deep <= r_slot;
                    end else if (r_slot == SW'(SLOTS - 1)) begin
                        r_err <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_item <= i_item;
                r_slot <= '0;
                r_st   <= ST_ERROR;
                r_oslot <= '0;
                r_okey <= '0;
                r_osum <= '0;
            end
            B_CHK: begin
                r_mask <= ent_m;
                r_okey <= r_item.key;
                if (hit) begin
                    r_st    <= ST_ADDED;
                    r_oslot <= 3'(r_slot);
                end else if (r_slot == SW'(SLOTS - 1)) begin
                    r_st <= ST_FULL;
                end else begin
                    r_slot <= r_slot + SW'(1);
                end
            end
            B_SUM: r_osum <= sat;
            B_EMIT: begin
                if (emit_go) begin
                    r_odata <= {5'd0, 3'(r_deep), r_hi, r_lo, r_osum, r_okey, r_oslot, r_st};
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### design/keyed_time_strip_accumulator_top.sv
// Keyed time-strip accumulator, top level.
// Path to a result: the front divides the time bit-serially and pushes to the queue;
// the back pops, reads and checks one slot after another, adds, then emits (an item
// refused in error goes straight to emit). Throughput is set by the front's divider:
// it takes no new item until it has pushed the last. Reset (synchronous, active low)
// starts a clearing pass over every slot-table entry; no transfer in then.
`default_nettype none
module keyed_time_strip_accumulator_top
    import ktsa_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEF,
    parameter int SLOTS    = SLOTS_DEF,
    parameter int FUNCS    = FUNCS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // strip_length register
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // vertex_index[9:0], func_number[12:10], sample_value[44:13],
    // sample_time[68:45], zero pad [71:69]
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], slot_used[4:2], strip_key[29:5], new_sum[77:30],
    // min_strip[102:78], max_strip[127:103], max_slot_seen[130:128], pad
    output logic [135:0]      m_axis_tdata
);
    logic [LEN_W-1:0] r_strip_len;
    logic  clr_done, push, full, pop, empty;
    t_item f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            r_strip_len <= i_cfg_wdata;
        end
    end

    ktsa_front #(.VERTICES(VERTICES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (clr_done),
        .i_strip_len (r_strip_len),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_vertex    (s_axis_tdata[9:0]),
        .i_func      (s_axis_tdata[12:10]),
        .i_value     (s_axis_tdata[44:13]),
        .i_time      (s_axis_tdata[68:45]),
        .o_push      (push),
        .o_item      (f_item),
        .i_full      (full)
    );

    // queue lets the divider start the next item while the back searches
    ktsa_fifo #(.W($bits(t_item))) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_empty (empty)
    );

    ktsa_back #(.VERTICES(VERTICES), .SLOTS(SLOTS), .FUNCS(FUNCS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clr_done (clr_done),
        .i_empty    (empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );
endmodule
`default_nettype wire
